/* rtl/set_assoc_cache_tag_round_robin_core_assert.svh */
// Assertion macros used by the checker of the cache tag core.
`ifndef SET_ASSOC_CACHE_TAG_ROUND_ROBIN_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_ROUND_ROBIN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SACRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SACRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sacrr_pkg.sv */
// Shared types and constants of the cache tag core.
`timescale 1ns / 1ps
`default_nettype none
package sacrr_pkg;

  // Raw set index width: index_bits is a 4-bit register.
  localparam int IDX_W = 15;

  // Reduction of the raw index by a set count that is not a power of two.
  localparam int MOD_STEPS  = 4;
  localparam int MOD_PASSES = 4;
  localparam int MOD_PASS_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS    = 2'd2;

  typedef enum logic [1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_CONFLICT   = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_RESOLVE
  } state_t;

endpackage
`default_nettype wire

/* rtl/sacrr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sacrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/sacrr_split.sv */
// Address split: tag from the top bits, raw set index from the bits below it.
`timescale 1ns / 1ps
`default_nettype none
module sacrr_split
  import sacrr_pkg::*;
#(
  parameter int ADDR_BITS = 32
) (
  input  wire logic [31:0]          address,
  input  wire logic [3:0]           index_bits,
  input  wire logic [5:0]           tag_bits,
  output logic      [ADDR_BITS-1:0] tag,
  output logic      [IDX_W-1:0]     idx
);

  localparam logic [6:0] AW = 7'(ADDR_BITS);

  logic [ADDR_BITS-1:0] addr;
  logic [6:0]           tb;
  logic [6:0]           rest;
  logic [6:0]           ib;
  logic [6:0]           off;
  logic [ADDR_BITS-1:0] shifted;
  logic [15:0]          mask;

  always_comb begin
    addr    = ADDR_BITS'(address);
    tb      = (7'(tag_bits) > AW) ? AW : 7'(tag_bits);
    rest    = AW - tb;
    ib      = (7'(index_bits) > rest) ? rest : 7'(index_bits);
    off     = rest - ib;
    tag     = (tb == 7'd0) ? '0 : (addr >> rest);
    shifted = addr >> off;
    mask    = (16'd1 << ib) - 16'd1;
    idx     = IDX_W'(shifted) & mask[IDX_W-1:0];
  end

endmodule
`default_nettype wire

/* rtl/set_assoc_cache_tag_round_robin_core.sv */
// Set-associative cache tag store with round-robin replacement: top level.
// One access per item: the tag and set index are cut from the address, the set's row
// (every way's valid, dirty and tag, plus the set's victim pointer) is read from one RAM,
// and the updated row is written back with the result. When SETS is not a power of two,
// ST_MOD first reduces the raw index modulo SETS; ST_READ then fetches the set row from the
// RAM with registered read data, and ST_RESOLVE writes it back once the output is free.
// A new item is taken while the previous result still waits at the output. After reset the
// row RAM is cleared, one set per cycle; no item is taken meanwhile, while configuration
// writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_tag_round_robin_core
  import sacrr_pkg::*;
#(
  parameter int WAYS      = 8,
  parameter int SETS      = 256,
  parameter int ADDR_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  kind,
  input  wire logic [31:0]           address,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 outcome,
  output logic [2:0]                 way_used,
  output logic [31:0]                compulsory_misses,
  output logic [31:0]                conflict_misses
);

  localparam int TAG_W   = ADDR_BITS;
  localparam int LANE_W  = TAG_W + 2;
  localparam int PTR_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W   = WAYS * LANE_W + PTR_W;
  localparam int KTOP    = IDX_W - 1;
  localparam bit IS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam logic [IDX_W-1:0] SET_MASK = IDX_W'(SETS - 1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  state_t state, state_next;

  logic [3:0]            ways_in_use;
  logic [3:0]            index_bits;
  logic [5:0]            tag_bits;

  logic                  kind_q;
  logic [TAG_W-1:0]      tag_q;
  logic [IDX_W-1:0]      rem;
  logic [IDX_W-1:0]      rem_next;
  logic [MOD_PASS_W-1:0] mod_pass;
  logic [SET_W-1:0]      clr_idx;

  logic [TAG_W-1:0]      split_tag;
  logic [IDX_W-1:0]      split_idx;

  logic                  ram_we;
  logic [SET_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      row_new;

  logic [4:0]            wn;
  logic                  hit;
  logic                  empty;
  logic [PTR_W-1:0]      hit_way;
  logic [PTR_W-1:0]      inv_way;
  logic [PTR_W-1:0]      ptr;
  logic [PTR_W-1:0]      ptr_use;
  logic [PTR_W-1:0]      ptr_inc;
  logic [PTR_W-1:0]      way_sel;
  logic [LANE_W-1:0]     lane;
  outcome_t              outcome_new;
  outcome_t              outcome_q;

  logic                  in_acc;
  logic                  done;

  sacrr_split #(
    .ADDR_BITS (ADDR_BITS)
  ) u_split (
    .address    (address),
    .index_bits (index_bits),
    .tag_bits   (tag_bits),
    .tag        (split_tag),
    .idx        (split_idx)
  );

  sacrr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (SET_W'(rem)),
    .rdata (rd_row)
  );

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= 4'd8;
      index_bits  <= 4'd8;
      tag_bits    <= 6'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        CFG_INDEX_BITS:  index_bits  <= cfg_data[3:0];
        CFG_TAG_BITS:    tag_bits    <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Raw index reduction, MOD_STEPS conditional subtracts of SETS shifted per pass.
  always_comb begin
    int          k;
    logic [31:0] d;
    rem_next = rem;
    for (int j = 0; j < MOD_STEPS; j++) begin
      k = KTOP - MOD_STEPS * int'(mod_pass) - j;
      d = '0;
      if (k >= 0) begin
        d = 32'(SETS) << k;
        if (32'(rem_next) >= d) begin
          rem_next = rem_next - IDX_W'(d);
        end
      end
    end
  end

  // Lookup over the ways of the row just read, then build the row to write back.
  always_comb begin
    if (ways_in_use == 4'd0) begin
      wn = 5'd1;
    end else if (5'(ways_in_use) > 5'(WAYS)) begin
      wn = 5'(WAYS);
    end else begin
      wn = 5'(ways_in_use);
    end
    hit     = 1'b0;
    empty   = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lane    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      lane = rd_row[w*LANE_W +: LANE_W];
      if (5'(w) < wn && lane[LANE_W-1] && lane[TAG_W-1:0] == tag_q) begin
        hit     = 1'b1;
        hit_way = PTR_W'(w);
      end
      if (5'(w) < wn && !lane[LANE_W-1]) begin
        empty   = 1'b1;
        inv_way = PTR_W'(w);
      end
    end
    ptr     = rd_row[ROW_W-1 -: PTR_W];
    ptr_use = (5'(ptr) >= wn) ? '0 : ptr;
    ptr_inc = ((5'(ptr_use) + 5'd1) == wn) ? '0 : ptr_use + PTR_W'(1);
    if (hit) begin
      way_sel     = hit_way;
      outcome_new = OUT_HIT;
    end else if (empty) begin
      way_sel     = inv_way;
      outcome_new = OUT_COMPULSORY;
    end else begin
      way_sel     = ptr_use;
      outcome_new = OUT_CONFLICT;
    end
    row_new = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      if (PTR_W'(w) == way_sel) begin
        if (hit) begin
          if (kind_q) begin
            row_new[w*LANE_W + TAG_W] = 1'b1;
          end
        end else begin
          row_new[w*LANE_W +: LANE_W] = {1'b1, kind_q, tag_q};
        end
      end
    end
    // Advance the victim pointer on evictions only.
    if (!hit && !empty) begin
      row_new[ROW_W-1 -: PTR_W] = ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    done       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = SET_W'(rem);
    ram_wdata  = row_new;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        if (clr_idx == LAST_SET) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = IS_POW2 ? ST_READ : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_pass == MOD_PASS_W'(MOD_PASSES - 1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        // Hold the row until the output register is free.
        if (!out_valid || out_ready) begin
          done       = 1'b1;
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_q   <= kind;
      tag_q    <= split_tag;
      rem      <= IS_POW2 ? (split_idx & SET_MASK) : split_idx;
      mod_pass <= '0;
    end else if (state == ST_MOD) begin
      rem      <= rem_next;
      mod_pass <= mod_pass + MOD_PASS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      compulsory_misses <= '0;
      conflict_misses   <= '0;
    end else if (done) begin
      out_valid <= 1'b1;
      if (outcome_new == OUT_COMPULSORY && compulsory_misses != '1) begin
        compulsory_misses <= compulsory_misses + 32'd1;
      end
      if (outcome_new == OUT_CONFLICT && conflict_misses != '1) begin
        conflict_misses <= conflict_misses + 32'd1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      outcome_q <= outcome_new;
      way_used  <= 3'(way_sel);
    end
  end

  assign outcome = outcome_q;

endmodule
`default_nettype wire

/* rtl/sacrr_checker.sv */
// Port-level checker of the cache tag core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_round_robin_core_assert.svh"
module sacrr_checker
  import sacrr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  outcome,
  input wire logic [31:0] compulsory_misses,
  input wire logic [31:0] conflict_misses
);

  logic [1:0]  pending;
  logic        seen;
  logic [31:0] last_comp;
  logic [31:0] last_conf;
  logic        in_acc;
  logic        out_acc;
  logic        hit_out;
  logic        counts_same;
  logic        out_stall;
  logic [33:0] held;

  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;
  assign hit_out     = out_acc && seen && outcome == OUT_HIT;
  assign counts_same = compulsory_misses == last_comp && conflict_misses == last_conf;
  assign out_stall   = out_valid && !out_ready;
  assign held        = {outcome, compulsory_misses};

  // Items taken in but whose result has not yet left.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      seen    <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_comp <= compulsory_misses;
      last_conf <= conflict_misses;
    end
  end

  `SACRR_ASSERT_NOW(a_no_orphan, out_acc, pending != 2'd0, "result without an item")
  `SACRR_ASSERT_NOW(a_bounded, 1'b1, pending <= 2'd2, "too many items in flight")
  `SACRR_ASSERT_NOW(a_hit_counts, hit_out, counts_same, "hit changed a miss count")
  `SACRR_ASSERT_NOW(a_clear_after_reset, $fell(rst), !in_ready, "item taken before clear pass")
  `SACRR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(held), "stalled result changed")

endmodule

bind set_assoc_cache_tag_round_robin_core sacrr_checker u_checker (.*);
`default_nettype wire

/* tb/tag_lookup_monitor.sv */
// Channel monitor for the cache tag core: predicts every lookup and compares each result.
`timescale 1ns / 1ps
module tag_lookup_monitor
  import sacrr_pkg::*;
#(
  parameter int WAYS      = 8,
  parameter int SETS      = 256,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  kind,
  input  logic [31:0]           address,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            outcome,
  input  logic [2:0]            way_used,
  input  logic [31:0]           compulsory_misses,
  input  logic [31:0]           conflict_misses,
  output int                    mismatches,
  output int                    pending,
  output int                    hits_seen,
  output int                    compulsory_seen,
  output int                    conflict_seen
);

  typedef struct {
    outcome_t    result;
    logic [2:0]  way;
    logic [31:0] compulsory;
    logic [31:0] conflict;
  } lookup_t;

  logic [63:0] line_tag [SETS*WAYS];
  bit          line_valid [SETS*WAYS];
  int          rr_pointer [SETS];
  logic [31:0] compulsory_total;
  logic [31:0] conflict_total;
  logic [3:0]  ways_reg;
  logic [3:0]  index_reg;
  logic [5:0]  tag_reg;
  lookup_t     pending_lookups [$];
  lookup_t     oldest;

  // Write-back of dirty victims is not part of the result, so dirty marks are not kept.
  function automatic lookup_t resolve_access(input logic [31:0] addr);
    logic [63:0] a;
    logic [63:0] tag;
    logic [63:0] idx;
    int tb, ib, off, set_no, base, ways, way, p;
    bit found, empty;
    lookup_t r;
    a = 64'(addr);
    if (ADDR_BITS < 64) a &= (64'd1 << ADDR_BITS) - 64'd1;
    tb = (tag_reg > ADDR_BITS) ? ADDR_BITS : int'(tag_reg);
    tag = (tb == 0) ? 64'd0 : a >> (ADDR_BITS - tb);
    ib = (index_reg > ADDR_BITS - tb) ? ADDR_BITS - tb : int'(index_reg);
    off = ADDR_BITS - tb - ib;
    idx = 64'd0;
    if (ib > 0 && off < 64) begin
      idx = a >> off;
      if (ib < 64) idx &= (64'd1 << ib) - 64'd1;
    end
    set_no = int'(idx % SETS);
    base = set_no * WAYS;
    ways = (ways_reg == 0) ? 1 : (ways_reg > WAYS) ? WAYS : int'(ways_reg);
    found = 1'b0;
    empty = 1'b0;
    way = 0;
    for (int w = 0; w < ways && !found; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tag) begin
        found = 1'b1;
        way = w;
      end
    end
    if (found) begin
      r.result = OUT_HIT;
    end else begin
      for (int w = 0; w < ways && !empty; w++) begin
        if (!line_valid[base+w]) begin
          empty = 1'b1;
          way = w;
        end
      end
      if (empty) begin
        if (compulsory_total != '1) compulsory_total++;
        r.result = OUT_COMPULSORY;
      end else begin
        // a pointer left over from a wider setting restarts at way 0
        p = rr_pointer[set_no];
        if (p >= ways) p = 0;
        way = p;
        rr_pointer[set_no] = (p + 1) % ways;
        if (conflict_total != '1) conflict_total++;
        r.result = OUT_CONFLICT;
      end
      line_tag[base+way] = tag;
      line_valid[base+way] = 1'b1;
    end
    r.way = 3'(way);
    r.compulsory = compulsory_total;
    r.conflict = conflict_total;
    return r;
  endfunction

  function automatic void report_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS*WAYS; i++) line_valid[i] = 1'b0;
      for (int i = 0; i < SETS; i++) rr_pointer[i] = 0;
      compulsory_total = '0;
      conflict_total = '0;
      ways_reg = 4'd8;
      index_reg = 4'd8;
      tag_reg = 6'd16;
      pending_lookups.delete();
      mismatches = 0;
      hits_seen = 0;
      compulsory_seen = 0;
      conflict_seen = 0;
    end else begin
      // retire the result first: an item taken on the same edge cannot be its source
      if (out_valid && out_ready) begin
        case (outcome)
          OUT_HIT:        hits_seen++;
          OUT_COMPULSORY: compulsory_seen++;
          OUT_CONFLICT:   conflict_seen++;
          default: ;
        endcase
        if (pending_lookups.size() == 0) begin
          mismatches++;
          $display("%0t: result with no access outstanding, outcome %0d way %0d",
                   $time, outcome, way_used);
        end else begin
          oldest = pending_lookups.pop_front();
          report_field("outcome", oldest.result, outcome);
          report_field("way_used", oldest.way, way_used);
          report_field("compulsory_misses", oldest.compulsory, compulsory_misses);
          report_field("conflict_misses", oldest.conflict, conflict_misses);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WAYS_IN_USE: ways_reg = cfg_data[3:0];
          CFG_INDEX_BITS:  index_reg = cfg_data[3:0];
          CFG_TAG_BITS:    tag_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_lookups.push_back(resolve_access(address));
    end
    pending <= pending_lookups.size();
  end

endmodule

/* tb/set_assoc_cache_tag_round_robin_core_test.sv */
// Stimulus and verdict for the cache tag core, with the channel monitor beside the block.
`timescale 1ns / 1ps
module set_assoc_cache_tag_round_robin_core_test;
  import sacrr_pkg::*;

  localparam int WAYS         = 8;
  localparam int SETS         = 256;
  localparam int ADDR_BITS    = 32;
  localparam int ACCESS_COUNT = 1050;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = 1'b0;
  logic [31:0]           address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            outcome;
  logic [2:0]            way_used;
  logic [31:0]           compulsory_misses;
  logic [31:0]           conflict_misses;

  int mismatches, pending, hits_seen, compulsory_seen, conflict_seen;
  int sent = 0;
  int phases = 0;
  int cur_ways = 8;
  int cur_index = 8;
  int cur_tag = 16;
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_len = 0;

  set_assoc_cache_tag_round_robin_core #(
    .WAYS(WAYS), .SETS(SETS), .ADDR_BITS(ADDR_BITS)
  ) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .address(address),
    .out_valid(out_valid), .out_ready(out_ready), .outcome(outcome), .way_used(way_used),
    .compulsory_misses(compulsory_misses), .conflict_misses(conflict_misses)
  );

  tag_lookup_monitor #(
    .WAYS(WAYS), .SETS(SETS), .ADDR_BITS(ADDR_BITS)
  ) monitor (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .address(address),
    .out_valid(out_valid), .out_ready(out_ready), .outcome(outcome), .way_used(way_used),
    .compulsory_misses(compulsory_misses), .conflict_misses(conflict_misses),
    .mismatches(mismatches), .pending(pending), .hits_seen(hits_seen),
    .compulsory_seen(compulsory_seen), .conflict_seen(conflict_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Build an address from tag, set and offset under the current register values.
  function automatic logic [31:0] compose(input logic [63:0] tg, input logic [63:0] st,
                                          input logic [63:0] ofs);
    int tb, ib, off;
    logic [63:0] a;
    tb = (cur_tag > ADDR_BITS) ? ADDR_BITS : cur_tag;
    ib = (cur_index > ADDR_BITS - tb) ? ADDR_BITS - tb : cur_index;
    off = ADDR_BITS - tb - ib;
    a = (ofs & ((64'd1 << off) - 64'd1)) | ((st & ((64'd1 << ib) - 64'd1)) << off)
        | ((tg & ((64'd1 << tb) - 64'd1)) << (ADDR_BITS - tb));
    return a[31:0];
  endfunction

  task automatic send_access(input logic k, input logic [31:0] a);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    address <= a;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid and hold until every outstanding lookup has returned.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WAYS_IN_USE: cur_ways = data[3:0];
      CFG_INDEX_BITS:  cur_index = data[3:0];
      CFG_TAG_BITS:    cur_tag = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [5:0] ways_val, input logic [5:0] index_val,
                            input logic [5:0] tag_val);
    settle();
    write_reg(CFG_WAYS_IN_USE, ways_val);
    write_reg(CFG_INDEX_BITS, index_val);
    write_reg(CFG_TAG_BITS, tag_val);
    phases++;
  endtask

  initial begin : result_sink
    int stall;
    int hold_seen;
    hold_seen = 0;
    wait (rst == 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall = hold_len;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [5:0]  ways_val, index_val, tag_val;
    logic [63:0] tag_pool [12];
    logic [63:0] set_pool [3];
    logic [31:0] addr;
    int ew, ntags, nsets, span;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, address extremes
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);

    // four ways, one set: fill, hit, write hit, then rotate the victim pointer to 3
    set_config(6'd4, 6'd2, 6'd4);
    send_access(1'b0, compose(1, 1, 0));
    send_access(1'b1, compose(2, 1, '1));
    send_access(1'b0, compose(1, 1, 5));
    send_access(1'b1, compose(2, 1, 0));
    send_access(1'b0, compose(3, 1, 0));
    send_access(1'b0, compose(4, 1, 0));
    send_access(1'b1, compose(5, 1, 0));
    send_access(1'b0, compose(6, 1, 0));
    send_access(1'b0, compose(7, 1, 0));

    // narrow to two ways: the pointer is stale
    set_config(6'd2, 6'd2, 6'd4);
    send_access(1'b0, compose(8, 1, 0));
    // zero ways acts as one
    set_config(6'd0, 6'd2, 6'd4);
    send_access(1'b1, compose(9, 1, 0));
    // above the way count: the unused upper ways are still empty
    set_config(6'd15, 6'd2, 6'd4);
    send_access(1'b0, compose(10, 1, 0));
    // no tag bits
    set_config(6'd8, 6'd8, 6'd0);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    // tag wider than the address leaves no index
    set_config(6'd8, 6'd15, 6'd63);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b0, 32'h8000_0001);
    // wide index reduced to the set count
    set_config(6'd8, 6'd15, 6'd1);
    send_access(1'b1, 32'h7FFF_FFFF);
    // one set, one way
    set_config(6'd1, 6'd0, 6'd8);
    send_access(1'b0, 32'h1200_0000);
    send_access(1'b0, 32'h3400_0000);

    while (sent < ACCESS_COUNT) begin
      case ($urandom_range(0, 5))
        0:       ways_val = 6'd0;
        1:       ways_val = 6'($urandom_range(9, 15));
        2:       ways_val = 6'd8;
        default: ways_val = 6'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       index_val = 6'd0;
        1:       index_val = 6'd8;
        2:       index_val = 6'($urandom_range(9, 15));
        default: index_val = 6'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 5))
        0:       tag_val = 6'd0;
        1:       tag_val = 6'($urandom_range(32, 63));
        2:       tag_val = 6'($urandom_range(11, 31));
        default: tag_val = 6'($urandom_range(1, 10));
      endcase
      // upper data bits are beyond the 4-bit registers
      ways_val[5:4] = 2'($urandom_range(0, 3));
      index_val[5:4] = 2'($urandom_range(0, 3));
      set_config(ways_val, index_val, tag_val);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 6'($urandom));

      // up to three tags beyond the ways in use over one to three sets, so hits and evictions mix
      ew = (cur_ways == 0) ? 1 : (cur_ways > WAYS) ? WAYS : cur_ways;
      ntags = $urandom_range(1, ew + 3);
      nsets = $urandom_range(1, 3);
      for (int k = 0; k < ntags; k++) tag_pool[k] = {$urandom, $urandom};
      for (int k = 0; k < nsets; k++) set_pool[k] = {$urandom, $urandom};
      steady <= ($urandom_range(0, 3) == 0);
      if (phases % 5 == 0) begin
        hold_len <= $urandom_range(30, 60);
        hold_req <= hold_req + 1;
      end
      span = $urandom_range(40, 90);
      repeat (span) begin
        if ($urandom_range(0, 6) == 0) addr = $urandom;
        else addr = compose(tag_pool[$urandom_range(0, ntags - 1)],
                            set_pool[$urandom_range(0, nsets - 1)], {$urandom, $urandom});
        send_access(1'($urandom_range(0, 1)), addr);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("tb: %0d accesses checked over %0d register settings", sent, phases);
    $display("tb: %0d hits, %0d compulsory misses, %0d conflict misses",
             hits_seen, compulsory_seen, conflict_seen);
    if (mismatches == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
